### design/cws_pkg.sv
package cws_pkg;

  // Fixed slot count: slaves 1, 2, 4 and 8
  localparam int SLAVE_SLOTS = 4;

  // Stream payload widths
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;

  // Configuration register indexes
  localparam logic [1:0] CFG_COALESCE = 2'd0;
  localparam logic [1:0] CFG_MIN_GAP  = 2'd1;
  localparam logic [1:0] CFG_RETRY    = 2'd2;
  localparam logic [1:0] CFG_BACKOFF  = 2'd3;

  // Configuration reset values
  localparam logic [15:0] RST_COALESCE = 16'd40;
  localparam logic [15:0] RST_MIN_GAP  = 16'd80;
  localparam logic [2:0]  RST_RETRY    = 3'd5;
  localparam logic [15:0] RST_BACKOFF  = 16'd30;

  typedef enum logic [1:0] {
    OP_REQUEST  = 2'd0,
    OP_TICK     = 2'd1,
    OP_COMPLETE = 2'd2,
    OP_CLEAR    = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_CAPTURE,
    CMD_REQ_RD,
    CMD_REQ_CALC,
    CMD_REQ_WR,
    CMD_TICK,
    CMD_SCAN,
    CMD_CPL_RD,
    CMD_CPL_WR,
    CMD_CLEAR,
    CMD_LOAD
  } cmd_e;

  typedef struct packed {
    op_e  op;
    logic bad_req;
    logic in_flight;
    logic bus_idle;
    logic hit;
    logic scan_end;
  } status_t;

  function automatic logic [3:0] slot_slave(logic [1:0] slot);
    logic [3:0] addr;
    case (slot)
      2'd0:    addr = 4'd1;
      2'd1:    addr = 4'd2;
      2'd2:    addr = 4'd4;
      default: addr = 4'd8;
    endcase
    return addr;
  endfunction

endpackage

### design/cws_datapath.sv
module cws_datapath #(
  parameter int COILS_PER_SLAVE = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cws_pkg::cmd_e                      cmd_i,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_index_i,
  input  logic [15:0]                        cfg_data_i,
  input  logic [cws_pkg::IN_TDATA_W-1:0]     in_tdata_i,
  input  logic [cws_pkg::IN_TUSER_W-1:0]     in_tuser_i,
  output cws_pkg::status_t                   status_o,
  output logic [cws_pkg::OUT_TDATA_W-1:0]    out_tdata_o
);

  localparam int N  = cws_pkg::SLAVE_SLOTS * COILS_PER_SLAVE;
  localparam int EW = $clog2(N);
  localparam int CW = (COILS_PER_SLAVE > 1) ? $clog2(COILS_PER_SLAVE) : 1;
  localparam int NW = $clog2(N + 1);
  localparam logic [CW-1:0] COIL_LAST = CW'(COILS_PER_SLAVE - 1);
  localparam logic [1:0]    OUTC_EXCEPTION = 2'd3;

  function automatic logic [EW-1:0] entry_idx(logic [1:0] s, logic [CW-1:0] c);
    return EW'(int'(s) * COILS_PER_SLAVE + int'(c));
  endfunction

  function automatic logic [CW+1:0] next_pos(logic [1:0] s, logic [CW-1:0] c);
    if (c == COIL_LAST) begin
      return {s + 2'd1, {CW{1'b0}}};
    end
    return {s, c + CW'(1)};
  endfunction

  function automatic logic is_before(logic [31:0] a, logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return diff[31];
  endfunction

  // Configuration
  logic [15:0] coalesce_q, min_gap_q, backoff_q;
  logic [2:0]  retry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coalesce_q <= cws_pkg::RST_COALESCE;
      min_gap_q  <= cws_pkg::RST_MIN_GAP;
      retry_q    <= cws_pkg::RST_RETRY;
      backoff_q  <= cws_pkg::RST_BACKOFF;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cws_pkg::CFG_COALESCE: coalesce_q <= cfg_data_i;
        cws_pkg::CFG_MIN_GAP:  min_gap_q  <= cfg_data_i;
        cws_pkg::CFG_RETRY:    retry_q    <= cfg_data_i[2:0];
        cws_pkg::CFG_BACKOFF:  backoff_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Captured item
  cws_pkg::op_e op_q;
  logic [7:0]   slave_q, coil_q;
  logic         val_q, bus_idle_q;
  logic [1:0]   outcome_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i == cws_pkg::CMD_CAPTURE) begin
      op_q       <= cws_pkg::op_e'(in_tuser_i);
      slave_q    <= in_tdata_i[7:0];
      coil_q     <= in_tdata_i[15:8];
      val_q      <= in_tdata_i[16];
      bus_idle_q <= in_tdata_i[17];
      outcome_q  <= in_tdata_i[19:18];
    end
  end

  // Request decode
  logic [1:0]    req_slot;
  logic          slot_ok, coil_ok, bad_req;
  logic [EW-1:0] req_e;

  always_comb begin
    slot_ok  = 1'b1;
    req_slot = 2'd0;
    case (slave_q)
      8'd1:    req_slot = 2'd0;
      8'd2:    req_slot = 2'd1;
      8'd4:    req_slot = 2'd2;
      8'd8:    req_slot = 2'd3;
      default: slot_ok  = 1'b0;
    endcase
  end

  assign coil_ok = coil_q < 8'(COILS_PER_SLAVE);
  assign bad_req = !(slot_ok && coil_ok);
  assign req_e   = entry_idx(req_slot, coil_q[CW-1:0]);

  // Block state
  logic [N-1:0]  valid_q, issued_q;
  logic [1:0]    ptr_slot_q, cur_slot_q, rd_slot_q;
  logic [CW-1:0] ptr_coil_q, cur_coil_q, rd_coil_q;
  logic [31:0]   time_q;
  logic          inflight_q, flight_val_q, alarm_q;
  logic [EW-1:0] flight_e_q;
  logic [NW-1:0] cnt_q;
  logic          rdv_q, rdlast_q;

  // Entry store, one read and one write port per field
  logic          value_mem   [N];
  logic [2:0]    retries_mem [N];
  logic [31:0]   ready_mem   [N];
  logic [31:0]   last_mem    [N];
  logic          rd_value_q;
  logic [2:0]    rd_retries_q;
  logic [31:0]   rd_ready_q, rd_lastiss_q;
  logic [31:0]   ready_calc_q, earliest_q;

  logic [EW-1:0] cur_e, rd_e, rd_addr;
  logic          hit, scan_end, do_issue;
  logic          req_wr, ours, is_exc, cpl_wr, cpl_drop, cpl_retry, cpl_ret_wr;
  logic [2:0]    ret_dec;
  logic [31:0]   req_ready_sel;
  logic [CW+1:0] cur_next, rd_next;

  assign cur_e    = entry_idx(cur_slot_q, cur_coil_q);
  assign rd_e     = entry_idx(rd_slot_q, rd_coil_q);
  assign cur_next = next_pos(cur_slot_q, cur_coil_q);
  assign rd_next  = next_pos(rd_slot_q, rd_coil_q);

  always_comb begin
    case (cmd_i)
      cws_pkg::CMD_SCAN:                       rd_addr = cur_e;
      cws_pkg::CMD_CPL_RD, cws_pkg::CMD_CPL_WR: rd_addr = flight_e_q;
      default:                                 rd_addr = req_e;
    endcase
  end

  // Scan check on the entry read last cycle
  assign hit      = rdv_q && valid_q[rd_e] && !is_before(time_q, rd_ready_q);
  assign scan_end = rdv_q && rdlast_q && !hit;
  assign do_issue = (cmd_i == cws_pkg::CMD_SCAN) && hit;

  // Request: keep an equal queued value, else store afresh
  assign req_ready_sel = (issued_q[req_e] && is_before(ready_calc_q, earliest_q)) ?
                         earliest_q : ready_calc_q;
  assign req_wr = (cmd_i == cws_pkg::CMD_REQ_WR) && !(valid_q[req_e] && rd_value_q == val_q);

  // Completion: only touches the entry if it still holds the value in flight
  assign ours       = valid_q[flight_e_q] && (rd_value_q == flight_val_q);
  assign is_exc     = outcome_q == OUTC_EXCEPTION;
  assign ret_dec    = (rd_retries_q != 3'd0) ? rd_retries_q - 3'd1 : 3'd0;
  assign cpl_wr     = cmd_i == cws_pkg::CMD_CPL_WR;
  assign cpl_drop   = cpl_wr && ours && (!is_exc || ret_dec == 3'd0);
  assign cpl_retry  = cpl_wr && ours && is_exc && ret_dec != 3'd0;
  assign cpl_ret_wr = cpl_wr && ours && is_exc;

  always_ff @(posedge clk_i) begin
    if (req_wr) begin
      value_mem[req_e] <= val_q;
    end
    rd_value_q <= value_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (req_wr) begin
      retries_mem[req_e] <= retry_q;
    end else if (cpl_ret_wr) begin
      retries_mem[flight_e_q] <= ret_dec;
    end
    rd_retries_q <= retries_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (req_wr) begin
      ready_mem[req_e] <= req_ready_sel;
    end else if (cpl_retry) begin
      ready_mem[flight_e_q] <= time_q + 32'(backoff_q);
    end
    rd_ready_q <= ready_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (do_issue) begin
      last_mem[rd_e] <= time_q;
    end
    rd_lastiss_q <= last_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == cws_pkg::CMD_REQ_CALC) begin
      ready_calc_q <= time_q + 32'(coalesce_q);
      earliest_q   <= rd_lastiss_q + 32'(min_gap_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      issued_q     <= '0;
      ptr_slot_q   <= '0;
      ptr_coil_q   <= '0;
      time_q       <= '0;
      inflight_q   <= 1'b0;
      flight_e_q   <= '0;
      flight_val_q <= 1'b0;
      alarm_q      <= 1'b0;
      cur_slot_q   <= '0;
      cur_coil_q   <= '0;
      rd_slot_q    <= '0;
      rd_coil_q    <= '0;
      cnt_q        <= '0;
      rdv_q        <= 1'b0;
      rdlast_q     <= 1'b0;
    end else begin
      if (req_wr) begin
        valid_q[req_e] <= 1'b1;
      end
      if (cpl_drop) begin
        valid_q[flight_e_q] <= 1'b0;
      end
      if (cpl_wr) begin
        inflight_q <= 1'b0;
        if (is_exc) begin
          alarm_q <= 1'b1;
        end
      end
      if (cmd_i == cws_pkg::CMD_CLEAR) begin
        alarm_q <= 1'b0;
      end
      if (cmd_i == cws_pkg::CMD_TICK) begin
        time_q     <= time_q + 32'd1;
        cur_slot_q <= ptr_slot_q;
        cur_coil_q <= ptr_coil_q;
        cnt_q      <= '0;
        rdv_q      <= 1'b0;
        rdlast_q   <= 1'b0;
      end
      if (cmd_i == cws_pkg::CMD_SCAN) begin
        {cur_slot_q, cur_coil_q} <= cur_next;
        rd_slot_q <= cur_slot_q;
        rd_coil_q <= cur_coil_q;
        rdv_q     <= cnt_q < NW'(N);
        rdlast_q  <= cnt_q == NW'(N - 1);
        if (cnt_q < NW'(N)) begin
          cnt_q <= cnt_q + NW'(1);
        end
      end
      if (do_issue) begin
        issued_q[rd_e]           <= 1'b1;
        inflight_q               <= 1'b1;
        flight_e_q               <= rd_e;
        flight_val_q             <= rd_value_q;
        {ptr_slot_q, ptr_coil_q} <= rd_next;
      end
    end
  end

  // Result being built, then the output register
  logic       res_iv_q, res_val_q;
  logic [3:0] res_slave_q, res_coil_q;
  logic       out_iv_q, out_val_q, out_rej_q, out_alarm_q;
  logic [3:0] out_slave_q, out_coil_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i == cws_pkg::CMD_CAPTURE) begin
      res_iv_q    <= 1'b0;
      res_slave_q <= '0;
      res_coil_q  <= '0;
      res_val_q   <= 1'b0;
    end else if (do_issue) begin
      res_iv_q    <= 1'b1;
      res_slave_q <= cws_pkg::slot_slave(rd_slot_q);
      res_coil_q  <= 4'(rd_coil_q);
      res_val_q   <= rd_value_q;
    end
    if (cmd_i == cws_pkg::CMD_LOAD) begin
      out_iv_q    <= res_iv_q;
      out_slave_q <= res_slave_q;
      out_coil_q  <= res_coil_q;
      out_val_q   <= res_val_q;
      out_rej_q   <= (op_q == cws_pkg::OP_REQUEST) && bad_req;
      out_alarm_q <= alarm_q;
    end
  end

  assign out_tdata_o = {4'b0, out_alarm_q, out_rej_q, out_val_q,
                        out_coil_q, out_slave_q, out_iv_q};

  assign status_o = '{op:        op_q,
                      bad_req:   bad_req,
                      in_flight: inflight_q,
                      bus_idle:  bus_idle_q,
                      hit:       hit,
                      scan_end:  scan_end};

endmodule

### design/cws_ctrl.sv
module cws_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  cws_pkg::status_t status_i,
  output cws_pkg::cmd_e    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_REQ_CALC,
    ST_REQ_WR,
    ST_SCAN,
    ST_CPL_WR,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = cws_pkg::CMD_IDLE;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = cws_pkg::CMD_CAPTURE;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_d = ST_FINISH;
        case (status_i.op)
          cws_pkg::OP_REQUEST: begin
            if (!status_i.bad_req) begin
              cmd_o   = cws_pkg::CMD_REQ_RD;
              state_d = ST_REQ_CALC;
            end
          end
          cws_pkg::OP_TICK: begin
            cmd_o = cws_pkg::CMD_TICK;
            if (status_i.bus_idle && !status_i.in_flight) begin
              state_d = ST_SCAN;
            end
          end
          cws_pkg::OP_COMPLETE: begin
            if (status_i.in_flight) begin
              cmd_o   = cws_pkg::CMD_CPL_RD;
              state_d = ST_CPL_WR;
            end
          end
          cws_pkg::OP_CLEAR: cmd_o = cws_pkg::CMD_CLEAR;
          default: ;
        endcase
      end
      ST_REQ_CALC: begin
        cmd_o   = cws_pkg::CMD_REQ_CALC;
        state_d = ST_REQ_WR;
      end
      ST_REQ_WR: begin
        cmd_o   = cws_pkg::CMD_REQ_WR;
        state_d = ST_FINISH;
      end
      ST_SCAN: begin
        cmd_o = cws_pkg::CMD_SCAN;
        if (status_i.hit || status_i.scan_end) begin
          state_d = ST_FINISH;
        end
      end
      ST_CPL_WR: begin
        cmd_o   = cws_pkg::CMD_CPL_WR;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o       = cws_pkg::CMD_LOAD;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

### design/coalescing_write_scheduler_unit.sv
// Steps per item: capture, dispatch, then a request read, calc and write (none if rejected),
//   a completion read and write, or a scan on a tick (one entry read a cycle), then the load.
// Throughput: one item at a time; the next is taken in the cycle after its result is loaded,
//   and a held result on the output can delay that load.
// Reset: asynchronous, active low; entry valid and issued bits, time, pointers, alarm and
//   configuration (40, 80, 5, 30) return to their initial values at once, no clearing pass.
module coalescing_write_scheduler_unit #(
  parameter int COILS_PER_SLAVE = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Request stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] slave address, [15:8] coil, [16] target_value, [17] bus_idle, [19:18] outcome,
  // [23:20] zero
  input  logic [cws_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] command
  input  logic [cws_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] issue_valid, [4:1] issue_slave, [8:5] issue_coil, [9] issue_value,
  // [10] request_rejected, [11] write_fail_alarm, [15:12] zero
  output logic [cws_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // Configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [1:0]                      cfg_index_i,
  input  logic [15:0]                     cfg_data_i
);

  // Controller sequences each item through the datapath; the datapath owns the
  // entry store, timers, scan cursor and the output register payload.
  cws_pkg::cmd_e    cmd;
  cws_pkg::status_t status;

  // Configuration is taken any cycle; the user must see that it is changed only while idle.
  assign cfg_ready_o = 1'b1;

  cws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cws_datapath #(
    .COILS_PER_SLAVE (COILS_PER_SLAVE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_tdata_i  (s_axis_tdata),
    .in_tuser_i  (s_axis_tuser),
    .status_o    (status),
    .out_tdata_o (m_axis_tdata)
  );

endmodule

### design/cws_checker.sv
module cws_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [cws_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // Held result must not change under back-pressure
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // One item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // An issued write names a real slave and is never a rejected request
  a_issue_slave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |->
      (m_axis_tdata[4:1] == 4'd1 || m_axis_tdata[4:1] == 4'd2 ||
       m_axis_tdata[4:1] == 4'd4 || m_axis_tdata[4:1] == 4'd8) && !m_axis_tdata[10])
    else $error("bad issue slave or rejected issue");

  // No issue: address and value fields are zero
  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[9:1] == 9'd0)
    else $error("issue fields set without an issue");

endmodule

bind coalescing_write_scheduler_unit cws_checker u_cws_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### sim/coalescing_write_scheduler_unit_test.sv
module coalescing_write_scheduler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COILS        = 4;
  localparam int ENTRIES      = cws_pkg::SLAVE_SLOTS * COILS;
  localparam int SETTLE       = 30;    // margin that covers the longest scan
  localparam int PRESS_CYCLES = 300;   // long receiver hold-off
  localparam int STALL_LIMIT  = 3000;  // cycles without any transfer

  // Completion outcome codes carried in tdata[19:18]
  typedef enum logic [1:0] {
    OC_ACK       = 2'd0,
    OC_TIMEOUT   = 2'd1,
    OC_INVALID   = 2'd2,
    OC_EXCEPTION = 2'd3
  } outcome_e;

  typedef struct packed {
    cws_pkg::op_e                   op;
    logic [cws_pkg::IN_TDATA_W-1:0] data;
  } cmd_item_t;

  // Result word as laid out on m_axis_tdata, lowest field last
  typedef struct packed {
    logic [3:0] pad;
    logic       alarm;
    logic       rejected;
    logic       value;
    logic [3:0] coil;
    logic [3:0] slave;
    logic       issued;
  } issue_word_t;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [cws_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [cws_pkg::IN_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [cws_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            cfg_valid_i   = 1'b0;
  logic                            cfg_ready_o;
  logic [1:0]                      cfg_index_i   = '0;
  logic [15:0]                     cfg_data_i    = '0;

  coalescing_write_scheduler_unit #(
    .COILS_PER_SLAVE(COILS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scheduler shadow: configuration, per-entry state and global state
  // ---------------------------------------------------------------------------
  logic [15:0] delay_ms   = cws_pkg::RST_COALESCE;
  logic [15:0] gap_ms     = cws_pkg::RST_MIN_GAP;
  logic [2:0]  tries_max  = cws_pkg::RST_RETRY;
  logic [15:0] backoff_ms = cws_pkg::RST_BACKOFF;

  logic        ent_vld   [ENTRIES];
  logic        ent_val   [ENTRIES];
  logic [2:0]  ent_tries [ENTRIES];
  logic [31:0] ent_ready [ENTRIES];
  logic [31:0] ent_last  [ENTRIES];
  logic        ent_once  [ENTRIES];
  int          scan_ptr  = 0;
  logic [31:0] now_ms    = '0;
  logic        wr_busy   = 1'b0;
  int          fl_ent    = 0;
  logic        fl_val    = 1'b0;
  logic        alarm     = 1'b0;

  cmd_item_t   cmd_q[$];        // items still to be offered
  issue_word_t sched_out_q[$];  // predicted result words, oldest first

  logic cmd_taken   = 1'b0;     // input transfer seen at the last rising edge
  int   gap_left    = 0;
  int   hold_left   = 0;
  int   press_left  = 0;
  int   press_req   = 0;
  int   press_seen  = 0;
  logic no_idle     = 1'b0;
  int   mismatches  = 0;
  int   stall_count = 0;

  // Wrapping time compare: a is earlier than b
  function automatic logic precedes(logic [31:0] a, logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return diff[31];
  endfunction

  // Advance the shadow by one accepted item and return the word it must produce
  function automatic issue_word_t schedule_step(cws_pkg::op_e op,
                                                logic [cws_pkg::IN_TDATA_W-1:0] d);
    issue_word_t r;
    int          slot;
    int          e;
    int          t;
    logic [31:0] due;
    logic [31:0] earliest;
    logic        ours;
    r = '0;
    case (op)
      cws_pkg::OP_REQUEST: begin
        case (d[7:0])
          8'd1:    slot = 0;
          8'd2:    slot = 1;
          8'd4:    slot = 2;
          8'd8:    slot = 3;
          default: slot = -1;
        endcase
        if (slot < 0 || d[15:8] >= COILS) begin
          r.rejected = 1'b1;
        end else begin
          e        = slot * COILS + int'(d[15:8]);
          due      = now_ms + 32'(delay_ms);
          earliest = ent_last[e] + 32'(gap_ms);
          // min gap only applies once the entry has gone out at least once
          if (ent_once[e] && precedes(due, earliest)) due = earliest;
          // equal value already queued: coalesce, keep retries and timing
          if (!(ent_vld[e] && ent_val[e] == d[16])) begin
            ent_val[e]   = d[16];
            ent_tries[e] = tries_max;
            ent_ready[e] = due;
            ent_vld[e]   = 1'b1;
          end
        end
      end
      cws_pkg::OP_TICK: begin
        now_ms = now_ms + 32'd1;
        if (d[17] && !wr_busy) begin
          for (t = 0; t < ENTRIES; t++) begin
            e = (scan_ptr + t) % ENTRIES;
            if (!r.issued && ent_vld[e] && !precedes(now_ms, ent_ready[e])) begin
              ent_last[e] = now_ms;
              ent_once[e] = 1'b1;
              wr_busy     = 1'b1;
              fl_ent      = e;
              fl_val      = ent_val[e];
              scan_ptr    = (e + 1) % ENTRIES;
              r.issued    = 1'b1;
              r.slave     = 4'(1 << (e / COILS));
              r.coil      = 4'(e % COILS);
              r.value     = ent_val[e];
            end
          end
        end
      end
      cws_pkg::OP_COMPLETE: begin
        // stray completion with nothing in flight changes nothing
        if (wr_busy) begin
          wr_busy = 1'b0;
          // re-requested with another value meanwhile: leave the entry be
          ours = ent_vld[fl_ent] && ent_val[fl_ent] == fl_val;
          if (outcome_e'(d[19:18]) != OC_EXCEPTION) begin
            if (ours) ent_vld[fl_ent] = 1'b0;
          end else begin
            alarm = 1'b1;
            if (ours) begin
              if (ent_tries[fl_ent] > 0) ent_tries[fl_ent] = ent_tries[fl_ent] - 3'd1;
              // zero retries left, including a zero limit: drop
              if (ent_tries[fl_ent] == 0) ent_vld[fl_ent] = 1'b0;
              else ent_ready[fl_ent] = now_ms + 32'(backoff_ms);
            end
          end
        end
      end
      default: alarm = 1'b0;
    endcase
    r.alarm = alarm;
    return r;
  endfunction

  function automatic cmd_item_t mk(cws_pkg::op_e op, logic [7:0] sid, logic [7:0] coil,
                                   logic val, logic idle, outcome_e oc);
    cmd_item_t it;
    it.op   = op;
    it.data = {4'd0, oc, idle, val, coil, sid};
    return it;
  endfunction

  // Mostly well-formed traffic; the unused fields carry random noise
  function automatic cmd_item_t rand_item();
    int           r;
    logic [7:0]   sid;
    logic [7:0]   coil;
    logic         idle;
    cws_pkg::op_e op;
    r    = $urandom_range(0, 99);
    sid  = 8'($urandom);
    coil = 8'($urandom);
    idle = 1'($urandom);
    if (r < 30) begin
      op = cws_pkg::OP_REQUEST;
      if ($urandom_range(0, 9) != 0) begin
        sid  = 8'(1 << $urandom_range(0, 3));
        coil = 8'($urandom_range(0, COILS - 1));
      end
    end else if (r < 78) begin
      op   = cws_pkg::OP_TICK;
      idle = 1'($urandom_range(0, 6) != 0);
    end else if (r < 93) begin
      op = cws_pkg::OP_COMPLETE;
    end else begin
      op = cws_pkg::OP_CLEAR;
    end
    return mk(op, sid, coil, 1'($urandom), idle, outcome_e'(2'($urandom)));
  endfunction

  // Idle lengths: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offers queued items at the falling edge, holds until the transfer
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_cmd
    cmd_item_t it;
    logic      nv;
    nv = s_axis_tvalid;
    if (!s_axis_tvalid || cmd_taken) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_q.size() != 0) begin
        it = cmd_q.pop_front();
        nv = 1'b1;
        s_axis_tuser <= it.op;
        s_axis_tdata <= it.data;
        gap_left = no_idle ? 0 : pick_gap();
      end
    end
    s_axis_tvalid <= nv;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_ready
    logic nr;
    if (press_req != press_seen) begin
      press_seen = press_req;
      press_left = PRESS_CYCLES;
    end
    if (press_left > 0) begin
      press_left--;
      nr = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      nr = 1'b0;
    end else if (!no_idle && $urandom_range(0, 3) == 0) begin
      hold_left = pick_gap();
      nr = (hold_left == 0);
    end else begin
      nr = 1'b1;
    end
    m_axis_tready <= nr;
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each input transfer, checks each output transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_ports
    issue_word_t got;
    issue_word_t want;
    if (!rst_ni) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (sched_out_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %h", got);
          mismatches++;
        end else begin
          want = sched_out_q.pop_front();
          if (got.issued != want.issued || got.slave != want.slave ||
              got.coil != want.coil || got.value != want.value ||
              got.rejected != want.rejected || got.alarm != want.alarm ||
              got.pad != want.pad) begin
            if (mismatches < 10)
              $display({"mismatch: exp iss %b sl %h co %h v %b rej %b al %b pad %h",
                        " | got iss %b sl %h co %h v %b rej %b al %b pad %h"},
                       want.issued, want.slave, want.coil, want.value, want.rejected,
                       want.alarm, want.pad, got.issued, got.slave, got.coil, got.value,
                       got.rejected, got.alarm, got.pad);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        sched_out_q.push_back(schedule_step(cws_pkg::op_e'(s_axis_tuser), s_axis_tdata));
    end
  end

  // Watchdog: too long without any transfer on any channel
  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("coalescing_write_scheduler_unit_test NOT OK");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration writes, only while the block is idle
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      cws_pkg::CFG_COALESCE: delay_ms   = val;
      cws_pkg::CFG_MIN_GAP:  gap_ms     = val;
      cws_pkg::CFG_RETRY:    tries_max  = val[2:0];
      cws_pkg::CFG_BACKOFF:  backoff_ms = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(int delay, int gap, int retries, int backoff);
    write_reg(cws_pkg::CFG_COALESCE, 16'(delay));
    write_reg(cws_pkg::CFG_MIN_GAP, 16'(gap));
    // upper bits of the retry word are don't-care noise
    write_reg(cws_pkg::CFG_RETRY, {13'($urandom), 3'(retries)});
    write_reg(cws_pkg::CFG_BACKOFF, 16'(backoff));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every item is taken and every result has come back
  task automatic drain();
    @(posedge clk_i);
    while (cmd_q.size() != 0 || s_axis_tvalid || sched_out_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic push_random(int n);
    repeat (n) cmd_q.push_back(rand_item());
  endtask

  initial begin : run
    for (int i = 0; i < ENTRIES; i++) begin
      ent_vld[i]   = 1'b0;
      ent_val[i]   = 1'b0;
      ent_tries[i] = '0;
      ent_ready[i] = '0;
      ent_last[i]  = '0;
      ent_once[i]  = 1'b0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part on short timings
    set_regs(1, 2, 2, 1);
    // bad slave, all ones, bad coil
    cmd_q.push_back(mk(cws_pkg::OP_REQUEST, 8'd0, 8'd0, 1'b0, 1'b0, OC_ACK));
    cmd_q.push_back(mk(cws_pkg::OP_REQUEST, 8'hFF, 8'hFF, 1'b1, 1'b1, OC_EXCEPTION));
    cmd_q.push_back(mk(cws_pkg::OP_REQUEST, 8'd8, 8'd4, 1'b1, 1'b0, OC_ACK));
    cmd_q.push_back(mk(cws_pkg::OP_REQUEST, 8'd1, 8'd0, 1'b1, 1'b0, OC_ACK));
    cmd_q.push_back(mk(cws_pkg::OP_REQUEST, 8'd1, 8'd0, 1'b1, 1'b0, OC_ACK));   // coalesced
    cmd_q.push_back(mk(cws_pkg::OP_COMPLETE, 8'd0, 8'd0, 1'b0, 1'b0, OC_ACK));  // none out
    cmd_q.push_back(mk(cws_pkg::OP_TICK, 8'd0, 8'd0, 1'b0, 1'b0, OC_ACK));      // bus busy
    cmd_q.push_back(mk(cws_pkg::OP_TICK, 8'd0, 8'd0, 1'b0, 1'b1, OC_ACK));      // entry 0
    cmd_q.push_back(mk(cws_pkg::OP_REQUEST, 8'd8, 8'd3, 1'b1, 1'b0, OC_ACK));
    cmd_q.push_back(mk(cws_pkg::OP_TICK, 8'd0, 8'd0, 1'b0, 1'b1, OC_ACK));      // in flight
    cmd_q.push_back(mk(cws_pkg::OP_COMPLETE, 8'd0, 8'd0, 1'b0, 1'b0, OC_EXCEPTION));
    cmd_q.push_back(mk(cws_pkg::OP_CLEAR, 8'd0, 8'd0, 1'b0, 1'b0, OC_ACK));
    cmd_q.push_back(mk(cws_pkg::OP_TICK, 8'd0, 8'd0, 1'b0, 1'b1, OC_ACK));      // slave 8
    cmd_q.push_back(mk(cws_pkg::OP_REQUEST, 8'd8, 8'd3, 1'b0, 1'b0, OC_ACK));   // gap
    cmd_q.push_back(mk(cws_pkg::OP_COMPLETE, 8'd0, 8'd0, 1'b0, 1'b0, OC_TIMEOUT));
    cmd_q.push_back(mk(cws_pkg::OP_TICK, 8'd0, 8'd0, 1'b0, 1'b1, OC_ACK));      // retry
    cmd_q.push_back(mk(cws_pkg::OP_COMPLETE, 8'd0, 8'd0, 1'b0, 1'b0, OC_EXCEPTION));
    cmd_q.push_back(mk(cws_pkg::OP_TICK, 8'd0, 8'd0, 1'b0, 1'b1, OC_ACK));
    cmd_q.push_back(mk(cws_pkg::OP_COMPLETE, 8'd0, 8'd0, 1'b0, 1'b0, OC_INVALID));
    cmd_q.push_back(mk(cws_pkg::OP_REQUEST, 8'd2, 8'd2, 1'b0, 1'b0, OC_ACK));
    cmd_q.push_back(mk(cws_pkg::OP_REQUEST, 8'd4, 8'd1, 1'b1, 1'b0, OC_ACK));
    cmd_q.push_back(mk(cws_pkg::OP_TICK, 8'd0, 8'd0, 1'b0, 1'b1, OC_ACK));
    cmd_q.push_back(mk(cws_pkg::OP_TICK, 8'd0, 8'd0, 1'b0, 1'b1, OC_ACK));
    cmd_q.push_back(mk(cws_pkg::OP_COMPLETE, 8'd0, 8'd0, 1'b0, 1'b0, OC_EXCEPTION));
    cmd_q.push_back(mk(cws_pkg::OP_CLEAR, 8'd0, 8'd0, 1'b0, 1'b0, OC_ACK));
    drain();

    // Low extremes; first half with no idling at all
    set_regs(0, 0, 1, 0);
    no_idle = 1'b1;
    push_random(100);
    while (cmd_q.size() != 0) @(posedge clk_i);
    no_idle = 1'b0;
    push_random(100);
    drain();

    // Short timings, long receiver hold-off while the sender keeps offering
    set_regs(3, 5, 7, 2);
    push_random(200);
    press_req++;
    drain();

    // Power-on timings
    set_regs(int'(cws_pkg::RST_COALESCE), int'(cws_pkg::RST_MIN_GAP),
             int'(cws_pkg::RST_RETRY), int'(cws_pkg::RST_BACKOFF));
    push_random(220);
    drain();

    // Zero retry limit: first exception drops the entry
    set_regs($urandom_range(0, 8), $urandom_range(0, 12), 0, $urandom_range(0, 6));
    push_random(150);
    drain();

    // High extremes
    set_regs(65535, 65535, 7, 65535);
    push_random(60);
    drain();

    if (mismatches == 0) begin
      $display("coalescing_write_scheduler_unit_test OK");
    end else begin
      $display("coalescing_write_scheduler_unit_test NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
design/cws_pkg.sv
design/cws_datapath.sv
design/cws_ctrl.sv
design/coalescing_write_scheduler_unit.sv
design/cws_checker.sv
sim/coalescing_write_scheduler_unit_test.sv
